// ===== rtl/rto_pkg.sv =====
// Shared types, codes and constants of the retransmit timeout estimator.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rto_pkg;

  // Time values in nanoseconds
  localparam int TIME_W = 40;
  localparam logic [TIME_W-1:0] TIME_MASK = '1;
  localparam int STAMP_W = 64;

  // Configuration port geometry (40-bit registers on a 64-bit data bus)
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;
  localparam int CFG_IW = 2;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_MIN_RTO = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MAX_RTO = 2'd1;
  localparam logic [CFG_IW-1:0] REG_GRAN    = 2'd2;

  // Reset values
  localparam logic [TIME_W-1:0] MIN_RTO_RST = TIME_W'(64'd1000000000);
  localparam logic [TIME_W-1:0] MAX_RTO_RST = TIME_W'(64'd60000000000);
  localparam logic [TIME_W-1:0] GRAN_RST    = TIME_W'(64'd1000000);
  localparam logic [TIME_W-1:0] RTO_RST     = TIME_W'(64'd1000000000);

  // Request codes
  localparam logic [1:0] REQ_OBSERVE  = 2'd0;
  localparam logic [1:0] REQ_BACKOFF  = 2'd1;
  localparam logic [1:0] REQ_PROGRESS = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TIME = 2'd1;
  localparam logic [1:0] ST_KARN     = 2'd2;

  // Queue sizes
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  // Operation handed from the front to the back
  typedef enum logic [1:0] {
    OP_NONE,
    OP_SAMPLE,
    OP_BACKOFF,
    OP_RESTORE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       status;
    logic [TIME_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] min_rto;
    logic [TIME_W-1:0] max_rto;
    logic [TIME_W-1:0] clock_granularity;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [STAMP_W-1:0] sent_time;
    logic [STAMP_W-1:0] ack_time;
    logic               retransmitted;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TIME_W-1:0] rto_now;
    logic [TIME_W-1:0] smoothed_rtt;
    logic [TIME_W-1:0] rtt_variation;
    logic              estimator_ready;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/rto_regs.sv =====
// Configuration registers (min_rto, max_rto, clock_granularity) behind an APB-style port.
// Depends on rto_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rto_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [rto_pkg::CFG_AW-1:0] paddr,
  input  wire logic [rto_pkg::CFG_DW-1:0] pwdata,
  output logic      [rto_pkg::CFG_DW-1:0] prdata,
  output logic                           pready,
  output rto_pkg::cfg_t                  cfg
);

  logic [rto_pkg::CFG_IW-1:0] idx;
  logic                       wr_en;
  logic [rto_pkg::TIME_W-1:0] wval;
  rto_pkg::cfg_t              cfg_r;

  assign idx    = paddr[rto_pkg::CFG_AW-1:3];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wval   = pwdata[rto_pkg::TIME_W-1:0];
  assign cfg    = cfg_r;

  // Write the addressed register; other addresses drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_rto           <= rto_pkg::MIN_RTO_RST;
      cfg_r.max_rto           <= rto_pkg::MAX_RTO_RST;
      cfg_r.clock_granularity <= rto_pkg::GRAN_RST;
    end else if (wr_en) begin
      case (idx)
        rto_pkg::REG_MIN_RTO: cfg_r.min_rto           <= wval;
        rto_pkg::REG_MAX_RTO: cfg_r.max_rto           <= wval;
        rto_pkg::REG_GRAN:    cfg_r.clock_granularity <= wval;
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      rto_pkg::REG_MIN_RTO: prdata = rto_pkg::CFG_DW'(cfg_r.min_rto);
      rto_pkg::REG_MAX_RTO: prdata = rto_pkg::CFG_DW'(cfg_r.max_rto);
      rto_pkg::REG_GRAN:    prdata = rto_pkg::CFG_DW'(cfg_r.clock_granularity);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rto_front.sv =====
// Front end: accepts requests, checks timestamps, applies Karn's rule and caps the
// sample, then queues a command for the back end. Depends on rto_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rto_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  rto_pkg::in_item_t      in_item,
  input  rto_pkg::cfg_t          cfg,
  input  wire logic              cmd_pop,
  output logic                   cmd_vld,
  output rto_pkg::cmd_t          cmd
);

  logic [rto_pkg::STAMP_W:0]    dt;
  logic                         ack_early;
  logic [rto_pkg::TIME_W-1:0]   sample_cap;
  rto_pkg::cmd_t                cmd_in;
  logic                         push_ok;

  rto_pkg::cmd_t                q_r [rto_pkg::CQ_DEPTH];
  logic [rto_pkg::CQ_AW-1:0]    wptr_r, wptr_nxt;
  logic [rto_pkg::CQ_AW-1:0]    rptr_r, rptr_nxt;
  logic [rto_pkg::CQ_AW:0]      cnt_r, cnt_nxt;

  // Elapsed time, with the borrow flagging a reversed pair
  assign dt        = {1'b0, in_item.ack_time} - {1'b0, in_item.sent_time};
  assign ack_early = dt[rto_pkg::STAMP_W];
  assign sample_cap = (dt[rto_pkg::STAMP_W-1:0] > rto_pkg::STAMP_W'(cfg.max_rto)) ?
                      cfg.max_rto : dt[rto_pkg::TIME_W-1:0];

  // Classify the request
  always_comb begin
    cmd_in.op     = rto_pkg::OP_NONE;
    cmd_in.status = rto_pkg::ST_OK;
    cmd_in.sample = sample_cap;
    case (in_item.req_type)
      rto_pkg::REQ_OBSERVE: begin
        if (ack_early) begin
          cmd_in.status = rto_pkg::ST_BAD_TIME;
        end else if (in_item.retransmitted) begin
          cmd_in.status = rto_pkg::ST_KARN;
        end else begin
          cmd_in.op = rto_pkg::OP_SAMPLE;
        end
      end
      rto_pkg::REQ_BACKOFF:  cmd_in.op = rto_pkg::OP_BACKOFF;
      rto_pkg::REQ_PROGRESS: cmd_in.op = rto_pkg::OP_RESTORE;
      default:               cmd_in.op = rto_pkg::OP_NONE;
    endcase
  end

  assign in_full = (cnt_r == (rto_pkg::CQ_AW+1)'(rto_pkg::CQ_DEPTH));
  assign push_ok = in_push && !in_full;
  assign cmd_vld = (cnt_r != '0);
  assign cmd     = q_r[rptr_r];

  // Advance queue pointers and fill count
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push_ok) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (cmd_pop && cmd_vld) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    case ({push_ok, cmd_pop && cmd_vld})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the command
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rto_back.sv =====
// Back end: updates the smoothed RTT and variation, then the timeout, and queues one
// result per command. Depends on rto_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rto_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  rto_pkg::cfg_t          cfg,
  input  wire logic              cmd_vld,
  input  rto_pkg::cmd_t          cmd,
  output logic                   cmd_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output rto_pkg::out_item_t     out_item
);

  localparam int TW = rto_pkg::TIME_W;

  // Estimator state
  logic          have_r;
  logic [TW-1:0] srtt_r, srtt_nxt;
  logic [TW-1:0] var_r, var_nxt;
  logic [TW-1:0] comp_r, comp_nxt;
  logic [TW-1:0] cur_r, cur_nxt;

  // Stage between the averaging and timeout steps
  logic          a_vld_r;
  rto_pkg::op_t  a_op_r;
  logic [1:0]    a_status_r;

  // Result queue
  rto_pkg::out_item_t         oq_r [rto_pkg::OQ_DEPTH];
  logic [rto_pkg::OQ_AW-1:0]  oq_wptr_r;
  logic [rto_pkg::OQ_AW-1:0]  oq_rptr_r;
  logic [rto_pkg::OQ_AW:0]    oq_cnt_r, oq_cnt_nxt;
  logic [rto_pkg::OQ_AW:0]    credit_used;
  logic                       oq_rd;
  rto_pkg::out_item_t         res;

  // Averaging terms
  logic [TW-1:0] diff;
  logic [TW+1:0] v_sum;
  logic [TW+2:0] s_sum;

  // Timeout terms
  logic [TW-1:0] quad;
  logic [TW-1:0] variation;
  logic [TW:0]   t_sum;
  logic [TW-1:0] raw_sat;
  logic [TW-1:0] raw_lo;
  logic [TW-1:0] raw_clamp;

  // Take a command only when a result slot is reserved for it
  assign credit_used = oq_cnt_r + (rto_pkg::OQ_AW+1)'(a_vld_r);
  assign cmd_pop     = cmd_vld && (credit_used < (rto_pkg::OQ_AW+1)'(rto_pkg::OQ_DEPTH));

  // Smoothing: rttvar = (3v + |s - x|) / 4, srtt = (7s + x) / 8
  assign diff  = (srtt_r > cmd.sample) ? (srtt_r - cmd.sample) : (cmd.sample - srtt_r);
  assign v_sum = {1'b0, var_r, 1'b0} + {2'b00, var_r} + {2'b00, diff};
  assign s_sum = {srtt_r, 3'b000} - {3'b000, srtt_r} + {3'b000, cmd.sample};

  always_comb begin
    srtt_nxt = srtt_r;
    var_nxt  = var_r;
    if (cmd_pop && cmd.op == rto_pkg::OP_SAMPLE) begin
      if (!have_r) begin
        srtt_nxt = cmd.sample;
        var_nxt  = {1'b0, cmd.sample[TW-1:1]};
      end else begin
        srtt_nxt = s_sum[TW+2:3];
        var_nxt  = v_sum[TW+1:2];
      end
    end
  end

  // Timeout from the updated averages: saturate, raise to min, lower to max
  assign quad      = (var_r[TW-1:TW-2] != 2'b00) ? rto_pkg::TIME_MASK : {var_r[TW-3:0], 2'b00};
  assign variation = (quad > cfg.clock_granularity) ? quad : cfg.clock_granularity;
  assign t_sum     = {1'b0, srtt_r} + {1'b0, variation};
  assign raw_sat   = (t_sum > {1'b0, cfg.max_rto}) ? cfg.max_rto : t_sum[TW-1:0];
  assign raw_lo    = (raw_sat < cfg.min_rto) ? cfg.min_rto : raw_sat;
  assign raw_clamp = (raw_lo > cfg.max_rto) ? cfg.max_rto : raw_lo;

  always_comb begin
    comp_nxt = comp_r;
    cur_nxt  = cur_r;
    if (a_vld_r) begin
      case (a_op_r)
        rto_pkg::OP_SAMPLE: begin
          comp_nxt = raw_clamp;
          cur_nxt  = raw_clamp;
        end
        rto_pkg::OP_BACKOFF: begin
          cur_nxt = (cur_r > {1'b0, cfg.max_rto[TW-1:1]}) ? cfg.max_rto : {cur_r[TW-2:0], 1'b0};
        end
        rto_pkg::OP_RESTORE: cur_nxt = comp_r;
        default:             cur_nxt = cur_r;
      endcase
    end
  end

  // Build the result of the item in the timeout step
  always_comb begin
    res.status          = a_status_r;
    res.rto_now         = cur_nxt;
    res.smoothed_rtt    = srtt_r;
    res.rtt_variation   = var_r;
    res.estimator_ready = have_r;
  end

  assign oq_rd     = out_pop && !out_empty;
  assign out_empty = (oq_cnt_r == '0);
  assign out_item  = oq_r[oq_rptr_r];

  always_comb begin
    case ({a_vld_r, oq_rd})
      2'b10:   oq_cnt_nxt = oq_cnt_r + 1'b1;
      2'b01:   oq_cnt_nxt = oq_cnt_r - 1'b1;
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  // Hold state, advance the stage and the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r     <= 1'b0;
      srtt_r     <= '0;
      var_r      <= '0;
      comp_r     <= rto_pkg::RTO_RST;
      cur_r      <= rto_pkg::RTO_RST;
      a_vld_r    <= 1'b0;
      a_op_r     <= rto_pkg::OP_NONE;
      a_status_r <= rto_pkg::ST_OK;
      oq_wptr_r  <= '0;
      oq_rptr_r  <= '0;
      oq_cnt_r   <= '0;
    end else begin
      if (cmd_pop && cmd.op == rto_pkg::OP_SAMPLE) begin
        have_r <= 1'b1;
      end
      srtt_r     <= srtt_nxt;
      var_r      <= var_nxt;
      comp_r     <= comp_nxt;
      cur_r      <= cur_nxt;
      a_vld_r    <= cmd_pop;
      a_op_r     <= cmd.op;
      a_status_r <= cmd.status;
      if (a_vld_r) begin
        oq_wptr_r <= oq_wptr_r + 1'b1;
      end
      if (oq_rd) begin
        oq_rptr_r <= oq_rptr_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  // Store the result
  always_ff @(posedge clk) begin
    if (a_vld_r) begin
      oq_r[oq_wptr_r] <= res;
    end
  end

  // Reserved slots never exceed the result queue
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= (rto_pkg::OQ_AW+1)'(rto_pkg::OQ_DEPTH))
    else $error("result queue over-committed");

  // Once a sample is taken the estimator stays ready
  a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |=> have_r)
    else $error("estimator ready dropped");

  // A fresh sample leaves the computed timeout within the upper clamp
  a_comp_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && a_op_r == rto_pkg::OP_SAMPLE) |=> (comp_r <= $past(cfg.max_rto)))
    else $error("computed timeout above max_rto");

  // Averages change only when a sample command is taken
  a_avg_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_pop && cmd.op == rto_pkg::OP_SAMPLE) |=> ($stable(srtt_r) && $stable(var_r)))
    else $error("averages changed without a sample");

endmodule

`default_nettype wire

// ===== rtl/retransmit_timeout_estimator_core.sv =====
// Top level of the retransmit timeout estimator: configuration registers, front end
// and back end. Depends on rto_pkg, rto_regs, rto_front and rto_back.
//
// Usage:
//   Requests enter on in_push/in_full/in_item (observe, timeout backoff, forward
//   progress). Each request yields exactly one result on out_empty/out_pop/out_item,
//   in order, carrying the status and the current timeout, smoothed RTT, variation
//   and ready flag.
//   An accepted request passes the command queue, the stage register and the result
//   queue before its result shows (out_empty low). Throughput: one request per cycle
//   while results drain, set by the averaging step, which feeds the next request.
//   The front holds up to 2 classified requests; the back reserves one of 4 result
//   slots per request taken, so a stalled receiver fills the result queue, then the
//   command queue, and only then raises in_full.
//   Reset (rst_n low at a clock edge) empties both queues, clears the estimator and
//   sets the timeout to one second and the registers to their defaults.
//   Registers lie at paddr 0 (min_rto), 8 (max_rto) and 16 (clock_granularity); write
//   them only while no request is outstanding.
`timescale 1ns / 1ps
`default_nettype none

module retransmit_timeout_estimator_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  rto_pkg::in_item_t               in_item,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output rto_pkg::out_item_t              out_item,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rto_pkg::CFG_AW-1:0] paddr,
  input  wire logic [rto_pkg::CFG_DW-1:0] pwdata,
  output logic      [rto_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);

  rto_pkg::cfg_t cfg;
  rto_pkg::cmd_t cmd;
  logic          cmd_vld;
  logic          cmd_pop;

  rto_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rto_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .cfg     (cfg),
    .cmd_pop (cmd_pop),
    .cmd_vld (cmd_vld),
    .cmd     (cmd)
  );

  rto_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_vld   (cmd_vld),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
